// ----- rtl/amch_pkg.sv -----
// Shared types and constants of the averaged magnetic compass heading block.
// Holds the sequencer states, register indexes, fixed-point widths and the arctangent table.
// No dependencies.
`default_nettype none

package amch_pkg;

  // Field and datapath widths.
  localparam int unsigned MAG_W     = 16;  // raw sample and hard-iron origin
  localparam int unsigned SCALE_W   = 16;  // soft-iron scale, unsigned Q1.15
  localparam int unsigned HEAD_W    = 15;  // heading, 1/64 degree
  localparam int unsigned DX_W      = 17;  // x after origin removal
  localparam int unsigned YV_W      = 18;  // scaled y
  localparam int unsigned PROD_W    = 33;  // y difference times scale
  localparam int unsigned FRAC_W    = 15;  // fraction bits of the scale
  localparam int unsigned CW        = 34;  // CORDIC vector width
  localparam int unsigned ACC_W     = 26;  // angle accumulator, 2^-16 degree
  localparam int unsigned TAB_W     = 22;  // arctangent table entry
  localparam int unsigned H_W       = 18;  // heading before wrapping, signed
  localparam int unsigned CORDIC_STEPS = 20;
  localparam int unsigned ITER_W    = 5;
  localparam int unsigned BIT_CNT_W = 4;   // counts the scale bits
  localparam int unsigned RND_SHIFT = 10;  // 2^-16 degree to 1/64 degree

  // Register reset values.
  localparam logic [SCALE_W-1:0] Y_SCALE_RST        = 16'd29519;
  localparam logic [HEAD_W-1:0]  HEADING_OFFSET_RST = 15'd6080;

  // Angle constants.
  localparam logic signed [ACC_W-1:0] ACC_HALF_TURN = 26'sd11796480;  // 180 degrees
  localparam logic signed [ACC_W-1:0] ACC_ROUND     = 26'sd512;
  localparam logic signed [H_W-1:0]   DEG64_HALF    = 18'sd11520;
  localparam logic signed [H_W-1:0]   DEG64_FULL    = 18'sd23040;
  localparam logic signed [CW-1:0]    NORM_LIMIT    = 34'sd536870912;  // 2^29

  typedef enum logic [1:0] {
    REG_ORIGIN_X       = 2'd0,
    REG_ORIGIN_Y       = 2'd1,
    REG_Y_SCALE        = 2'd2,
    REG_HEADING_OFFSET = 2'd3
  } amch_reg_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_UPD  = 7'b0000100,
    ST_NORM = 7'b0001000,
    ST_ROT  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_WRAP = 7'b1000000
  } amch_state_e;

  // atan(2^-i) in units of 2^-16 degree.
  function automatic logic [TAB_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
    logic [TAB_W-1:0] val;
    unique case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/averaged_magnetic_compass_heading.sv -----
// Top level of the averaged magnetic compass heading block: calibration, moving sum,
// CORDIC arctangent and heading wrap in one sequenced datapath.
// Depends on amch_pkg.
`default_nettype none

//  Channel  | Direction | Signals                                   | Contents
//  ---------+-----------+-------------------------------------------+---------------------------
//  s_axis   | in        | s_axis_tvalid/tready/tdata[31:0]          | mag_x [15:0], mag_y [31:16]
//  m_axis   | out       | m_axis_tvalid/tready/tdata[15:0]          | heading [14:0], zero [15]
//  cfg      | in        | cfg_valid_i/ready_o, cfg_index_i, cfg_data_i | register write
//
// The soft-iron multiply takes one scale bit a cycle, the normalisation makes one doubling a
// cycle while the summed vector is small, and the CORDIC makes one micro-rotation a cycle;
// the ring update sits between multiply and normalisation, and the final step and wrap follow.
// Reset clears the configuration to its defaults, the ring valid bits, the running sums and
// the write slot; no clearing pass is needed. A result waiting in the output register does
// not stop the next beat being accepted; only the final load waits for it to be taken.

module averaged_magnetic_compass_heading
  import amch_pkg::*;
#(
  parameter int unsigned WINDOW = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // mag_x [15:0], mag_y [31:16]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  // heading [14:0], zero fill [15]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned SX_W   = DX_W + SLOT_W;
  localparam int unsigned SY_W   = YV_W + SLOT_W;

  // Configuration registers.
  logic signed [MAG_W-1:0]  origin_x_q, origin_y_q;
  logic [SCALE_W-1:0]       y_scale_q;
  logic [HEAD_W-1:0]        heading_offset_q;

  // Sequencer and datapath registers.
  amch_state_e              state_q, state_d;
  logic signed [DX_W-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic [SCALE_W-1:0]       scale_sh_q, scale_sh_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [BIT_CNT_W-1:0]     bit_cnt_q, bit_cnt_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic signed [SX_W-1:0]   sum_x_q, sum_x_d;
  logic signed [SY_W-1:0]   sum_y_q, sum_y_d;
  logic signed [CW-1:0]     cx_q, cx_d, cy_q, cy_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [ITER_W-1:0]        iter_q, iter_d;
  logic signed [H_W-1:0]    h_q, h_d;
  logic [HEAD_W-1:0]        head_q, head_d;
  logic                     out_valid_q, out_valid_d;

  // Sample ring, one entry per window slot, with a valid bit per entry.
  logic signed [DX_W-1:0]   ring_x [WINDOW];
  logic signed [YV_W-1:0]   ring_y [WINDOW];
  logic [WINDOW-1:0]        ring_valid_q;
  logic signed [DX_W-1:0]   old_x_raw_q;
  logic signed [YV_W-1:0]   old_y_raw_q;
  logic                     old_valid_q;

  // Combinational helpers.
  logic                     in_fire;
  logic                     out_free;
  logic signed [DX_W-1:0]   old_x;
  logic signed [YV_W-1:0]   old_y;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [YV_W-1:0]   yv;
  logic signed [SX_W-1:0]   sum_x_new;
  logic signed [SY_W-1:0]   sum_y_new;
  logic                     vec_zero, vec_small;
  logic signed [CW-1:0]     rot_dx, rot_dy;
  logic signed [ACC_W-1:0]  atan_ext;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [H_W-1:0]    angle64;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, head_q};
  assign cfg_ready_o   = 1'b1;

  // A slot that has never been written holds zero.
  assign old_x = old_valid_q ? old_x_raw_q : '0;
  assign old_y = old_valid_q ? old_y_raw_q : '0;

  // Truncation toward zero of the Q1.15 product: bias negative values before the shift.
  assign prod_adj = prod_q + (prod_q[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : '0);
  assign yv       = prod_adj[PROD_W-1:FRAC_W];

  // Running sums follow the ring: the new sample comes in, the one it replaces goes out.
  assign sum_x_new = sum_x_q + SX_W'(dx_q) - SX_W'(old_x);
  assign sum_y_new = sum_y_q + SY_W'(yv) - SY_W'(old_y);

  assign vec_zero  = (cx_q == '0) && (cy_q == '0);
  assign vec_small = (cx_q > -NORM_LIMIT) && (cx_q < NORM_LIMIT) &&
                     (cy_q > -NORM_LIMIT) && (cy_q < NORM_LIMIT);

  assign rot_dx   = cy_q >>> iter_q;
  assign rot_dy   = cx_q >>> iter_q;
  assign atan_ext = ACC_W'(atan_entry(iter_q));

  // Round the angle half up to 1/64 degree; the angle may be negative.
  assign acc_rnd = acc_q + ACC_ROUND;
  assign angle64 = H_W'($signed(acc_rnd[ACC_W-1:RND_SHIFT]));

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q       <= '0;
      origin_y_q       <= '0;
      y_scale_q        <= Y_SCALE_RST;
      heading_offset_q <= HEADING_OFFSET_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_X:       origin_x_q       <= cfg_data_i;
        REG_ORIGIN_Y:       origin_y_q       <= cfg_data_i;
        REG_Y_SCALE:        y_scale_q        <= cfg_data_i;
        REG_HEADING_OFFSET: heading_offset_q <= cfg_data_i[HEAD_W-1:0];
      endcase
    end
  end

  // Sequencer next state and datapath.
  always_comb begin
    state_d     = state_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    scale_sh_d  = scale_sh_q;
    prod_d      = prod_q;
    bit_cnt_d   = bit_cnt_q;
    slot_d      = slot_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    acc_d       = acc_q;
    iter_d      = iter_q;
    h_d         = h_q;
    head_d      = head_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          dx_d       = DX_W'($signed(s_axis_tdata[15:0])) - DX_W'(origin_x_q);
          dy_d       = DX_W'($signed(s_axis_tdata[31:16])) - DX_W'(origin_y_q);
          scale_sh_d = y_scale_q;
          prod_d     = '0;
          bit_cnt_d  = '0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        // Shift and add, most significant scale bit first.
        prod_d     = (prod_q <<< 1) + (scale_sh_q[SCALE_W-1] ? PROD_W'(dy_q) : '0);
        scale_sh_d = scale_sh_q << 1;
        bit_cnt_d  = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BIT_CNT_W'(SCALE_W - 1)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        sum_x_d = sum_x_new;
        sum_y_d = sum_y_new;
        cx_d    = CW'(sum_x_new);
        cy_d    = CW'(sum_y_new);
        acc_d   = '0;
        slot_d  = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
        state_d = ST_NORM;
      end
      ST_NORM: begin
        priority if (vec_zero) begin
          acc_d   = '0;
          state_d = ST_FIN;
        end else if (vec_small) begin
          cx_d = cx_q <<< 1;
          cy_d = cy_q <<< 1;
        end else begin
          // Fold the left half-plane onto the right one.
          if (cx_q[CW-1]) begin
            cx_d  = -cx_q;
            cy_d  = -cy_q;
            acc_d = ACC_HALF_TURN;
          end
          iter_d  = '0;
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (cy_q > 0) begin
          cx_d  = cx_q + rot_dx;
          cy_d  = cy_q - rot_dy;
          acc_d = acc_q + atan_ext;
        end else begin
          cx_d  = cx_q - rot_dx;
          cy_d  = cy_q + rot_dy;
          acc_d = acc_q - atan_ext;
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        h_d     = DEG64_HALF - angle64 - H_W'(heading_offset_q);
        state_d = ST_WRAP;
      end
      ST_WRAP: begin
        // At most two full turns are added before the value is in range.
        priority if (h_q[H_W-1]) begin
          h_d = h_q + DEG64_FULL;
        end else if (out_free) begin
          head_d      = h_q[HEAD_W-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          // The heading waits here until the output register is free.
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bit_cnt_q    <= '0;
      iter_q       <= '0;
      slot_q       <= '0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      out_valid_q  <= 1'b0;
      ring_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      iter_q      <= iter_d;
      slot_q      <= slot_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_UPD) begin
        ring_valid_q[slot_q] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    scale_sh_q <= scale_sh_d;
    prod_q     <= prod_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    acc_q      <= acc_d;
    h_q        <= h_d;
    head_q     <= head_d;
  end

  // Ring memory: the outgoing entry is read when the beat is accepted, the new one
  // is written during the ring update.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      old_x_raw_q <= ring_x[slot_q];
      old_y_raw_q <= ring_y[slot_q];
    end
    if (state_q == ST_UPD) begin
      ring_x[slot_q] <= dx_q;
      ring_y[slot_q] <= yv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_valid_q <= 1'b0;
    end else if (in_fire) begin
      old_valid_q <= ring_valid_q[slot_q];
    end
  end

  // A sample is worked on alone: the input closes for the cycle after a beat.
  a_single_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input accepted while a sample is in progress");

  // A result appears only from the final wrap step.
  a_out_from_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_WRAP))
    else $error("result loaded outside the wrap step");

  // The CORDIC index never runs past the table.
  a_iter_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROT) |-> (iter_q < ITER_W'(CORDIC_STEPS)))
    else $error("CORDIC index out of range");

  // A delivered heading lies within one turn.
  a_heading_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (head_q < HEAD_W'(DEG64_FULL)))
    else $error("heading outside one turn");

endmodule

`default_nettype wire
